@@ sv/cap_pkg.sv @@
// cap_pkg: shared widths, constants, codes and handshake structs for the
// cascaded altitude controller. No dependencies.
package cap_pkg;

    // Fixed point format of all fractional quantities
    localparam int FRAC_BITS = 8;

    // Field widths
    localparam int GAIN_W   = 15;
    localparam int GOAL_W   = 11;
    localparam int MEAS_W   = 10;
    localparam int CLIMB_W  = 13;
    localparam int THR_W    = 9;
    localparam int OUT16_W  = 16;
    localparam int INTEG_W  = 32;
    localparam int HERR_W   = 12;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_PROP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_INTEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DERIV = 3'd4;

    // Gain scale divisors and throttle clamp
    localparam int DIV_SMALL = 100;
    localparam int DIV_LARGE = 10000;
    localparam int THR_LIMIT = 250;

    // Derived datapath widths
    localparam int TS_W        = OUT16_W + FRAC_BITS;
    localparam int CLIMB_Q_W   = CLIMB_W + FRAC_BITS;
    localparam int SERR_RAW_W  = ((TS_W > CLIMB_Q_W) ? TS_W : CLIMB_Q_W) + 1;
    localparam int SERR_W      = (SERR_RAW_W > INTEG_W) ? INTEG_W : SERR_RAW_W;
    localparam int WIDE_W      = ((SERR_RAW_W > INTEG_W) ? SERR_RAW_W : INTEG_W) + 1;
    localparam int MUL_B_W     = (SERR_W + 1 > INTEG_W) ? SERR_W + 1 : INTEG_W;
    localparam int X_W         = MUL_B_W + 1;
    localparam int PROD_W      = GAIN_W + MUL_B_W;
    localparam int DIGIT_W     = 8;
    localparam int DIV_DIGITS  = (PROD_W + FRAC_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int DIV_W       = DIV_DIGITS * DIGIT_W;
    localparam int CNT_W       = $clog2(DIV_DIGITS);
    localparam int REM_W       = $clog2(DIV_LARGE) + 1;
    localparam int TERM_W      = DIV_W + 1;
    localparam int SUM_W       = TERM_W + 2;

    // Loop term being worked on
    typedef enum logic [2:0] {
        TERM_OP = 3'd0,   // outer proportional
        TERM_OI = 3'd1,   // outer integral
        TERM_IP = 3'd2,   // inner proportional
        TERM_II = 3'd3,   // inner integral
        TERM_ID = 3'd4    // inner derivative
    } term_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  capture;   // latch the input item
        logic  load;      // height error, outer integral update
        logic  mul;       // multiply and launch the divider
        logic  acc;       // store the signed quotient as a term
        logic  speed;     // target speed from the outer terms
        logic  err;       // speed error and inner integral update
        logic  finish;    // load the result register
        term_t term;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;   // divider finishes its last digit this cycle
    } sts_t;

endpackage

@@ sv/cap_div.sv @@
// cap_div: constant divisor unit (100 or 10000), eight quotient bits per
// cycle by restoring division. Depends on cap_pkg.
module cap_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      large_div,
    input  logic [cap_pkg::DIV_W-1:0] dividend,
    output logic [cap_pkg::DIV_W-1:0] quotient,
    output logic                      last
);

    logic [cap_pkg::DIV_W-1:0] quo_reg;
    logic [cap_pkg::REM_W-1:0] rem_reg;
    logic [cap_pkg::REM_W-1:0] dsr_reg;
    logic [cap_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;

    logic [cap_pkg::DIV_W-1:0] quo_next;
    logic [cap_pkg::REM_W-1:0] rem_next;

    // One digit: eight shift, compare and subtract steps
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < cap_pkg::DIGIT_W; i++) begin
            rem_next = {rem_next[cap_pkg::REM_W-2:0], quo_next[cap_pkg::DIV_W-1]};
            quo_next = {quo_next[cap_pkg::DIV_W-2:0], 1'b0};
            if (rem_next >= dsr_reg) begin
                rem_next    = rem_next - dsr_reg;
                quo_next[0] = 1'b1;
            end
        end
    end

    assign last     = busy_reg && (cnt_reg == cap_pkg::CNT_W'(cap_pkg::DIV_DIGITS - 1));
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + cap_pkg::CNT_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= large_div ? cap_pkg::REM_W'(cap_pkg::DIV_LARGE)
                                 : cap_pkg::REM_W'(cap_pkg::DIV_SMALL);
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_no_early_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !last) |=> busy_reg)
        else $error("divider stopped before its last digit");

endmodule

@@ sv/cap_dp.sv @@
// cap_dp: datapath of the cascaded altitude controller: gain registers,
// loop state, shared multiplier, divider and result register.
// Depends on cap_pkg and cap_div.
module cap_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cap_pkg::cmd_t                         cmd,
    output cap_pkg::sts_t                         sts,
    input  logic                                  cfg_wr_en,
    input  logic [cap_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cap_pkg::GAIN_W-1:0]            cfg_wdata,
    input  logic signed [cap_pkg::GOAL_W-1:0]     s_goal_height,
    input  logic [cap_pkg::MEAS_W-1:0]            s_measured_height,
    input  logic signed [cap_pkg::CLIMB_W-1:0]    s_climb_rate,
    output logic signed [cap_pkg::THR_W-1:0]      m_throttle_correction,
    output logic signed [cap_pkg::OUT16_W-1:0]    m_speed_setpoint,
    output logic signed [cap_pkg::OUT16_W-1:0]    m_outer_integ_term,
    output logic signed [cap_pkg::OUT16_W-1:0]    m_inner_integ_term
);

    localparam int SUM_W  = cap_pkg::SUM_W;
    localparam int WIDE_W = cap_pkg::WIDE_W;
    localparam int INTEG_W = cap_pkg::INTEG_W;

    localparam logic signed [SUM_W-1:0] FRAC_MASK =
        {{(SUM_W - cap_pkg::FRAC_BITS){1'b0}}, {cap_pkg::FRAC_BITS{1'b1}}};
    localparam logic signed [SUM_W-1:0] TS_MAX =
        {{(SUM_W - cap_pkg::TS_W + 1){1'b0}}, {(cap_pkg::TS_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] TS_MIN = ~TS_MAX;
    localparam logic signed [SUM_W-1:0] THR_MAX =
        SUM_W'(cap_pkg::THR_LIMIT) <<< cap_pkg::FRAC_BITS;
    localparam logic signed [SUM_W-1:0] THR_MIN = -THR_MAX;
    localparam logic signed [SUM_W-1:0] O16_MAX =
        {{(SUM_W - cap_pkg::OUT16_W + 1){1'b0}}, {(cap_pkg::OUT16_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] O16_MIN = ~O16_MAX;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = ~INTEG_MAX;
    localparam logic signed [WIDE_W-1:0] WIDE_I32_MAX =
        {{(WIDE_W - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_I32_MIN = ~WIDE_I32_MAX;

    // Integer part, truncated toward zero
    function automatic logic signed [SUM_W-1:0] trunc_frac(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] bias;
        bias = v[SUM_W-1] ? FRAC_MASK : '0;
        return (v + bias) >>> cap_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [cap_pkg::OUT16_W-1:0] sat16(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = (v > O16_MAX) ? O16_MAX : ((v < O16_MIN) ? O16_MIN : v);
        return c[cap_pkg::OUT16_W-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_integ(
        input logic signed [INTEG_W:0] s);
        if (s[INTEG_W] != s[INTEG_W-1]) begin
            return s[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        return s[INTEG_W-1:0];
    endfunction

    // Gains
    logic [cap_pkg::GAIN_W-1:0] kop_reg, koi_reg, kip_reg, kii_reg, kid_reg;

    // Captured item
    logic signed [cap_pkg::GOAL_W-1:0]  goal_reg;
    logic [cap_pkg::MEAS_W-1:0]         meas_reg;
    logic signed [cap_pkg::CLIMB_W-1:0] climb_reg;

    // Loop state
    logic signed [INTEG_W-1:0]         oint_reg, iint_reg;
    logic signed [cap_pkg::SERR_W-1:0] prev_reg;

    // Working registers
    logic signed [cap_pkg::TS_W-1:0]   tspeed_reg;
    logic signed [cap_pkg::SERR_W-1:0] serr_reg;
    logic signed [cap_pkg::TERM_W-1:0] op_reg, oi_reg, ip_reg, ii_reg, id_reg;
    logic                              neg_reg;

    // Result register
    logic signed [cap_pkg::THR_W-1:0]   thr_out_reg;
    logic signed [cap_pkg::OUT16_W-1:0] ts_out_reg, oi_out_reg, ii_out_reg;

    logic signed [cap_pkg::HERR_W-1:0]   herr;
    logic signed [INTEG_W:0]             oint_sum, iint_sum;
    logic signed [cap_pkg::SERR_W:0]     diff;
    logic [cap_pkg::GAIN_W-1:0]          gain_sel;
    logic signed [cap_pkg::X_W-1:0]      x_sel, x_abs;
    logic                                shift_sel, large_sel;
    logic [cap_pkg::MUL_B_W-1:0]         mag;
    logic [cap_pkg::PROD_W-1:0]          prod;
    logic [cap_pkg::DIV_W-1:0]           dividend, quotient;
    logic signed [cap_pkg::TERM_W-1:0]   quo_ext, term_val;
    logic signed [SUM_W-1:0]             osum, isum, thr_sat;
    logic signed [WIDE_W-1:0]            serr_wide;
    logic signed [cap_pkg::SERR_W-1:0]   serr_sat;

    assign herr = cap_pkg::HERR_W'(goal_reg) - cap_pkg::HERR_W'($signed({1'b0, meas_reg}));
    assign oint_sum = (INTEG_W + 1)'(oint_reg) + (INTEG_W + 1)'(herr);
    assign iint_sum = (INTEG_W + 1)'(iint_reg) - (INTEG_W + 1)'(climb_reg);
    assign diff = (cap_pkg::SERR_W + 1)'(serr_reg) - (cap_pkg::SERR_W + 1)'(prev_reg);

    // Operand selection for the shared multiplier
    always_comb begin
        case (cmd.term)
            cap_pkg::TERM_OP: begin
                gain_sel = kop_reg; x_sel = cap_pkg::X_W'(herr);
                shift_sel = 1'b1; large_sel = 1'b0;
            end
            cap_pkg::TERM_OI: begin
                gain_sel = koi_reg; x_sel = cap_pkg::X_W'(oint_reg);
                shift_sel = 1'b1; large_sel = 1'b1;
            end
            cap_pkg::TERM_IP: begin
                gain_sel = kip_reg; x_sel = cap_pkg::X_W'(serr_reg);
                shift_sel = 1'b0; large_sel = 1'b0;
            end
            cap_pkg::TERM_II: begin
                gain_sel = kii_reg; x_sel = cap_pkg::X_W'(iint_reg);
                shift_sel = 1'b1; large_sel = 1'b1;
            end
            cap_pkg::TERM_ID: begin
                gain_sel = kid_reg; x_sel = cap_pkg::X_W'(diff);
                shift_sel = 1'b0; large_sel = 1'b0;
            end
            default: begin
                gain_sel = '0; x_sel = '0;
                shift_sel = 1'b0; large_sel = 1'b0;
            end
        endcase
    end

    // Sign-magnitude multiply; the divider's dividend register follows it
    assign x_abs    = x_sel[cap_pkg::X_W-1] ? -x_sel : x_sel;
    assign mag      = x_abs[cap_pkg::MUL_B_W-1:0];
    assign prod     = cap_pkg::PROD_W'(gain_sel) * cap_pkg::PROD_W'(mag);
    assign dividend = shift_sel ? (cap_pkg::DIV_W'(prod) << cap_pkg::FRAC_BITS)
                                : cap_pkg::DIV_W'(prod);

    cap_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mul),
        .large_div (large_sel),
        .dividend  (dividend),
        .quotient  (quotient),
        .last      (sts.div_last)
    );

    // Quotient truncates toward zero: negate the magnitude result
    assign quo_ext  = {1'b0, quotient};
    assign term_val = neg_reg ? -quo_ext : quo_ext;

    assign osum = SUM_W'(op_reg) + SUM_W'(oi_reg);
    assign isum = SUM_W'(ip_reg) + SUM_W'(ii_reg) + SUM_W'(id_reg);
    assign thr_sat = (isum > THR_MAX) ? THR_MAX : ((isum < THR_MIN) ? THR_MIN : isum);

    assign serr_wide = WIDE_W'(tspeed_reg) - (WIDE_W'(climb_reg) <<< cap_pkg::FRAC_BITS);
    always_comb begin
        if (serr_wide > WIDE_I32_MAX) begin
            serr_sat = WIDE_I32_MAX[cap_pkg::SERR_W-1:0];
        end else if (serr_wide < WIDE_I32_MIN) begin
            serr_sat = WIDE_I32_MIN[cap_pkg::SERR_W-1:0];
        end else begin
            serr_sat = serr_wide[cap_pkg::SERR_W-1:0];
        end
    end

    // Gains and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kop_reg  <= '0;
            koi_reg  <= '0;
            kip_reg  <= '0;
            kii_reg  <= '0;
            kid_reg  <= '0;
            oint_reg <= '0;
            iint_reg <= '0;
            prev_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    cap_pkg::REG_OUTER_PROP:  kop_reg <= cfg_wdata;
                    cap_pkg::REG_OUTER_INTEG: koi_reg <= cfg_wdata;
                    cap_pkg::REG_INNER_PROP:  kip_reg <= cfg_wdata;
                    cap_pkg::REG_INNER_INTEG: kii_reg <= cfg_wdata;
                    cap_pkg::REG_INNER_DERIV: kid_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                oint_reg <= sat_integ(oint_sum);
            end
            if (cmd.err) begin
                iint_reg <= sat_integ(iint_sum);
            end
            if (cmd.finish) begin
                prev_reg <= serr_reg;
            end
        end
    end

    // Item, terms and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            goal_reg  <= s_goal_height;
            meas_reg  <= s_measured_height;
            climb_reg <= s_climb_rate;
        end
        if (cmd.mul) begin
            neg_reg <= x_sel[cap_pkg::X_W-1];
        end
        if (cmd.acc) begin
            case (cmd.term)
                cap_pkg::TERM_OP: op_reg <= term_val;
                cap_pkg::TERM_OI: oi_reg <= term_val;
                cap_pkg::TERM_IP: ip_reg <= term_val;
                cap_pkg::TERM_II: ii_reg <= term_val;
                cap_pkg::TERM_ID: id_reg <= term_val;
                default: ;
            endcase
        end
        if (cmd.speed) begin
            if (osum > TS_MAX) begin
                tspeed_reg <= TS_MAX[cap_pkg::TS_W-1:0];
            end else if (osum < TS_MIN) begin
                tspeed_reg <= TS_MIN[cap_pkg::TS_W-1:0];
            end else begin
                tspeed_reg <= osum[cap_pkg::TS_W-1:0];
            end
        end
        if (cmd.err) begin
            serr_reg <= serr_sat;
        end
        if (cmd.finish) begin
            thr_out_reg <= cap_pkg::THR_W'(trunc_frac(thr_sat));
            ts_out_reg  <= cap_pkg::OUT16_W'(trunc_frac(SUM_W'(tspeed_reg)));
            oi_out_reg  <= sat16(trunc_frac(SUM_W'(oi_reg)));
            ii_out_reg  <= sat16(trunc_frac(SUM_W'(ii_reg)));
        end
    end

    assign m_throttle_correction = thr_out_reg;
    assign m_speed_setpoint      = ts_out_reg;
    assign m_outer_integ_term    = oi_out_reg;
    assign m_inner_integ_term    = ii_out_reg;

endmodule

@@ sv/cap_ctrl.sv @@
// cap_ctrl: sequencer of the cascaded altitude controller; steps the
// datapath through the five loop terms. Depends on cap_pkg.
module cap_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output cap_pkg::cmd_t cmd,
    input  cap_pkg::sts_t sts
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_ACC    = 8'b0001_0000,
        S_SPEED  = 8'b0010_0000,
        S_ERR    = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    cap_pkg::term_t term_reg, term_next;
    logic           m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                term_next  = cap_pkg::TERM_OP;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (sts.div_last) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                case (term_reg)
                    cap_pkg::TERM_OP: begin
                        term_next  = cap_pkg::TERM_OI;
                        state_next = S_MUL;
                    end
                    cap_pkg::TERM_OI: state_next = S_SPEED;
                    cap_pkg::TERM_IP: begin
                        term_next  = cap_pkg::TERM_II;
                        state_next = S_MUL;
                    end
                    cap_pkg::TERM_II: begin
                        term_next  = cap_pkg::TERM_ID;
                        state_next = S_MUL;
                    end
                    cap_pkg::TERM_ID: state_next = S_FINISH;
                    default: state_next = S_IDLE;
                endcase
            end
            S_SPEED: begin
                cmd.speed  = 1'b1;
                state_next = S_ERR;
            end
            S_ERR: begin
                cmd.err    = 1'b1;
                term_next  = cap_pkg::TERM_IP;
                state_next = S_MUL;
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = cmd.finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            term_reg    <= cap_pkg::TERM_OP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            term_reg    <= term_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_last |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_finish_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH) |-> (term_reg == cap_pkg::TERM_ID))
        else $error("result reached before the derivative term");

endmodule

@@ sv/cascade_altitude_pid.sv @@
// cascade_altitude_pid: top level of the cascaded altitude hold controller.
// Depends on cap_pkg, cap_ctrl and cap_dp (which holds cap_div).
//
// Each item carries a goal height, a measured height and a climb rate and
// yields one result: the clamped throttle correction, the target speed and
// the integer parts of both integral terms. An outer PI loop turns the
// height error into a target speed in Q8; an inner PID loop turns the speed
// error into a throttle correction clamped to plus or minus 250. The five
// loop terms are worked one after another through one 15 by 32 bit
// multiplier and one divider by 100 or 10000 that retires eight quotient
// bits per cycle. The block takes the next item only after the last one has
// been worked to its result. The result sits in an output register, so a new
// item is taken while the last result still waits for m_ready. The user must
// write gains over the cfg port only while idle; the block does not enforce
// this. Gains reset to zero, as do both integrals and the stored speed error.
module cascade_altitude_pid (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // gain writes
    input  logic                                  cfg_wr_en,
    input  logic [cap_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cap_pkg::GAIN_W-1:0]            cfg_wdata,
    // input items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [cap_pkg::GOAL_W-1:0]     s_goal_height,
    input  logic [cap_pkg::MEAS_W-1:0]            s_measured_height,
    input  logic signed [cap_pkg::CLIMB_W-1:0]    s_climb_rate,
    // result items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cap_pkg::THR_W-1:0]      m_throttle_correction,
    output logic signed [cap_pkg::OUT16_W-1:0]    m_speed_setpoint,
    output logic signed [cap_pkg::OUT16_W-1:0]    m_outer_integ_term,
    output logic signed [cap_pkg::OUT16_W-1:0]    m_inner_integ_term
);

    cap_pkg::cmd_t cmd;
    cap_pkg::sts_t sts;

    // Sequencer: one-hot state machine, term counter and result valid
    cap_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Datapath: gains, loop state, multiplier, divider, result register
    cap_dp u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .sts                   (sts),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_goal_height         (s_goal_height),
        .s_measured_height     (s_measured_height),
        .s_climb_rate          (s_climb_rate),
        .m_throttle_correction (m_throttle_correction),
        .m_speed_setpoint      (m_speed_setpoint),
        .m_outer_integ_term    (m_outer_integ_term),
        .m_inner_integ_term    (m_inner_integ_term)
    );

endmodule
